@@ src/heightmap_normal_generator_top_defines.svh @@
// Assertion macros used by the heightmap normal generator top module.
`ifndef HEIGHTMAP_NORMAL_GENERATOR_TOP_DEFINES_SVH
`define HEIGHTMAP_NORMAL_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HNG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define HNG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/hng_pkg.sv @@
// Constants and helpers for the heightmap normal generator.
`default_nettype none

package hng_pkg;

  localparam int H_W    = 8;   // height sample
  localparam int ADDR_W = 10;  // line buffer address, column and row counters
  localparam int SIDE_W = 11;  // grid side register
  localparam int Q_W    = 16;  // Q1.15 component
  localparam int BIT_W  = 4;   // bit position of the root search
  localparam int SQ_W   = 16;  // square of a difference
  localparam int S_W    = 17;  // sum of squares plus the y term
  localparam int ODD_W  = 17;  // 2*cand - 1
  localparam int OSQ_W  = 34;  // odd squared
  localparam int PROD_W = 51;  // odd squared times s
  localparam int RHS_W  = 48;  // a squared shifted up by 32

  localparam int LINE_DEPTH = 1024;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd257;
  localparam logic [SIDE_W-1:0] SIDE_MIN   = 11'd3;
  localparam logic [SIDE_W-1:0] SIDE_MAX   = 11'd1024;

  // y component before scaling is 10, so its square is 100
  localparam logic [SQ_W-1:0] Y_SQ = 16'd100;

  localparam logic [Q_W-1:0] Q_ONE = 16'h7FFF;

  // component slots of the shared root unit
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  // Saturate a root-search magnitude at 32767 and apply the sign.
  function automatic logic [Q_W-1:0] to_q15(input logic [Q_W-1:0] q, input logic neg);
    logic [Q_W-2:0] mag;
    logic [Q_W-1:0] pos;
    mag = q[Q_W-1] ? Q_ONE[Q_W-2:0] : q[Q_W-2:0];
    pos = {1'b0, mag};
    return neg ? Q_W'(-pos) : pos;
  endfunction

endpackage

`default_nettype wire

@@ src/heightmap_normal_generator_top.sv @@
// Heightmap normal generator: line buffers, sequencer and shared root/divide unit.
`default_nettype none
`include "heightmap_normal_generator_top_defines.svh"

// Height samples enter in raster order; each sample of row r (r >= 1) yields the
// unit normal of the vertex one row above it, in signed Q1.15, with (0,1,0) on the
// grid border. The block takes one sample at a time. An interior vertex waits on the
// shared trial-square unit, which makes 48 bit trials (three components of 16 bits
// each) interleaved over the multiplier pipeline (square, then scale by s), one
// trial per cycle. The result waits in an output register, so the next sample is
// taken while it is still unclaimed. grid_side is clamped to 3..1024; the user must
// write it only while the block is idle, and the block itself does not enforce this.
module heightmap_normal_generator_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [hng_pkg::SIDE_W-1:0]        cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic [hng_pkg::H_W-1:0]           height_i,
  input  wire logic                              frame_start_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic signed [hng_pkg::Q_W-1:0]    normal_x_o,
  output      logic signed [hng_pkg::Q_W-1:0]    normal_y_o,
  output      logic signed [hng_pkg::Q_W-1:0]    normal_z_o,
  output      logic [hng_pkg::ADDR_W-1:0]        vertex_column_o,
  output      logic [hng_pkg::ADDR_W-1:0]        vertex_row_o
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_READ  = 8'b0000_0010,
    ST_DIFF  = 8'b0000_0100,
    ST_SQR   = 8'b0000_1000,
    ST_SUM   = 8'b0001_0000,
    ST_ITER  = 8'b0010_0000,
    ST_DRAIN = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration and position
  logic [hng_pkg::SIDE_W-1:0] grid_side_q;
  logic [hng_pkg::SIDE_W-1:0] side_eff;
  logic [hng_pkg::ADDR_W-1:0] col_cnt_q, col_cnt_d;
  logic [hng_pkg::ADDR_W-1:0] row_cnt_q, row_cnt_d;
  logic [hng_pkg::H_W-1:0]    left_q;

  // current sample
  logic [hng_pkg::ADDR_W-1:0] c_q, r_q;
  logic [hng_pkg::H_W-1:0]    h_q;
  logic [hng_pkg::ADDR_W-1:0] pos_c;
  logic [hng_pkg::ADDR_W-1:0] pos_r;

  // line buffers
  logic [hng_pkg::H_W-1:0] above_mem [hng_pkg::LINE_DEPTH];
  logic [hng_pkg::H_W-1:0] two_mem   [hng_pkg::LINE_DEPTH];
  logic [hng_pkg::H_W-1:0] mid_rd_q, right_rd_q, down_rd_q;

  // differences and sums
  logic [hng_pkg::H_W-1:0]  left_v, right_v, adl, adu;
  logic                     dl_pos, du_pos, interior, emit;
  logic [hng_pkg::H_W-1:0]  adl_q, adu_q;
  logic                     neg_x_q, neg_z_q;
  logic [hng_pkg::SQ_W-1:0] dlsq_q, dusq_q;
  logic [hng_pkg::S_W-1:0]  s_q;
  logic [hng_pkg::ADDR_W-1:0] vcol_q, vrow_q;

  // shared trial-square unit
  logic [1:0]                 comp_q;
  logic [hng_pkg::BIT_W-1:0]  bit_q;
  logic [hng_pkg::Q_W-1:0]    q_q [3];
  logic [hng_pkg::Q_W-1:0]    cand;
  logic [hng_pkg::ODD_W-1:0]  odd;
  logic                       p1_valid_q, p2_valid_q;
  logic [1:0]                 p1_comp_q, p2_comp_q;
  logic [hng_pkg::Q_W-1:0]    p1_cand_q, p2_cand_q;
  logic [hng_pkg::OSQ_W-1:0]  osq_q;
  logic [hng_pkg::PROD_W-1:0] prod_q;
  logic [hng_pkg::SQ_W-1:0]   a2;
  logic                       trial_ok;
  logic                       issue;

  // output register
  logic                       out_valid_q;
  logic                       out_load;
  logic [hng_pkg::Q_W-1:0]    nx_q, ny_q, nz_q;
  logic [hng_pkg::ADDR_W-1:0] ocol_q, orow_q;

  // ---------------------------------------------------------------- control
  always_comb begin
    if (grid_side_q < hng_pkg::SIDE_MIN) begin
      side_eff = hng_pkg::SIDE_MIN;
    end else if (grid_side_q > hng_pkg::SIDE_MAX) begin
      side_eff = hng_pkg::SIDE_MAX;
    end else begin
      side_eff = grid_side_q;
    end
  end

  // position of an incoming sample, wrapping if the side has shrunk
  always_comb begin
    logic [hng_pkg::SIDE_W-1:0] col_fs, row_fs, row_t;
    col_fs = frame_start_i ? '0 : {1'b0, col_cnt_q};
    row_fs = frame_start_i ? '0 : {1'b0, row_cnt_q};
    if (col_fs >= side_eff) begin
      pos_c = '0;
      row_t = row_fs + hng_pkg::SIDE_W'(1);
    end else begin
      pos_c = col_fs[hng_pkg::ADDR_W-1:0];
      row_t = row_fs;
    end
    pos_r = (row_t >= side_eff) ? '0 : row_t[hng_pkg::ADDR_W-1:0];
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign issue      = (state_q == ST_ITER);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_READ;
      ST_READ:  state_d = ST_DIFF;
      ST_DIFF: begin
        if (!emit) begin
          state_d = ST_IDLE;
        end else if (!interior) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_SQR;
        end
      end
      ST_SQR:   state_d = ST_SUM;
      ST_SUM:   state_d = ST_ITER;
      ST_ITER:  if (comp_q == hng_pkg::COMP_Z && bit_q == '0) state_d = ST_DRAIN;
      ST_DRAIN: if (!p1_valid_q && !p2_valid_q) state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // next sample position after this one
  always_comb begin
    logic [hng_pkg::SIDE_W-1:0] col_inc, row_inc;
    col_inc   = {1'b0, c_q} + hng_pkg::SIDE_W'(1);
    row_inc   = {1'b0, r_q} + hng_pkg::SIDE_W'(1);
    col_cnt_d = col_inc[hng_pkg::ADDR_W-1:0];
    row_cnt_d = r_q;
    if (col_inc >= side_eff) begin
      col_cnt_d = '0;
      row_cnt_d = (row_inc >= side_eff) ? '0 : row_inc[hng_pkg::ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      grid_side_q <= hng_pkg::SIDE_RESET;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      left_q      <= '0;
      p1_valid_q  <= 1'b0;
      p2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      p1_valid_q <= issue;
      p2_valid_q <= p1_valid_q;
      if (cfg_we_i) begin
        grid_side_q <= cfg_wdata_i;
      end
      if (state_q == ST_DIFF) begin
        col_cnt_q <= col_cnt_d;
        row_cnt_q <= row_cnt_d;
        left_q    <= mid_rd_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- line buffers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIFF) begin
      above_mem[c_q] <= h_q;
      two_mem[c_q]   <= mid_rd_q;
    end
    if (state_q == ST_READ) begin
      mid_rd_q   <= above_mem[c_q];
      right_rd_q <= above_mem[c_q + hng_pkg::ADDR_W'(1)];
      down_rd_q  <= two_mem[c_q];
    end
  end

  // ---------------------------------------------------------------- differences
  always_comb begin
    left_v   = (c_q == '0) ? '0 : left_q;
    // no column to the right of the last buffer entry
    right_v  = (c_q == hng_pkg::ADDR_W'(hng_pkg::LINE_DEPTH - 1)) ? '0 : right_rd_q;
    dl_pos   = right_v > left_v;
    du_pos   = h_q > down_rd_q;
    adl      = dl_pos ? right_v - left_v : left_v - right_v;
    adu      = du_pos ? h_q - down_rd_q : down_rd_q - h_q;
    emit     = (r_q != '0);
    interior = (c_q != '0) && (({1'b0, c_q} + hng_pkg::SIDE_W'(2)) <= side_eff)
               && (r_q >= hng_pkg::ADDR_W'(2));
  end

  // ---------------------------------------------------------------- trial unit
  always_comb begin
    cand = q_q[comp_q] | (hng_pkg::Q_W'(1) << bit_q);
    odd  = {cand, 1'b0} - hng_pkg::ODD_W'(1);
    case (p2_comp_q)
      hng_pkg::COMP_X: a2 = dlsq_q;
      hng_pkg::COMP_Y: a2 = hng_pkg::Y_SQ;
      default:         a2 = dusq_q;
    endcase
    // (2*cand-1)^2 * s <= a^2 * 2^32
    trial_ok = prod_q <= hng_pkg::PROD_W'({a2, 32'd0});
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      h_q <= height_i;
      c_q <= pos_c;
      r_q <= pos_r;
    end

    if (state_q == ST_DIFF) begin
      adl_q   <= adl;
      adu_q   <= adu;
      neg_x_q <= dl_pos;
      neg_z_q <= du_pos;
      vcol_q  <= c_q;
      vrow_q  <= r_q - hng_pkg::ADDR_W'(1);
      q_q[hng_pkg::COMP_X] <= '0;
      q_q[hng_pkg::COMP_Y] <= hng_pkg::Q_ONE;
      q_q[hng_pkg::COMP_Z] <= '0;
    end

    if (state_q == ST_SQR) begin
      dlsq_q <= hng_pkg::SQ_W'(adl_q) * hng_pkg::SQ_W'(adl_q);
      dusq_q <= hng_pkg::SQ_W'(adu_q) * hng_pkg::SQ_W'(adu_q);
    end

    if (state_q == ST_SUM) begin
      s_q    <= hng_pkg::S_W'(dlsq_q) + hng_pkg::S_W'(dusq_q) + hng_pkg::S_W'(hng_pkg::Y_SQ);
      comp_q <= hng_pkg::COMP_X;
      bit_q  <= '1;
      q_q[hng_pkg::COMP_X] <= '0;
      q_q[hng_pkg::COMP_Y] <= '0;
      q_q[hng_pkg::COMP_Z] <= '0;
    end

    if (issue) begin
      if (comp_q == hng_pkg::COMP_Z) begin
        comp_q <= hng_pkg::COMP_X;
        bit_q  <= bit_q - hng_pkg::BIT_W'(1);
      end else begin
        comp_q <= comp_q + 2'd1;
      end
    end

    // stage 1: square the odd candidate; stage 2: scale by s; then compare
    p1_comp_q <= comp_q;
    p1_cand_q <= cand;
    osq_q     <= hng_pkg::OSQ_W'(odd) * hng_pkg::OSQ_W'(odd);
    p2_comp_q <= p1_comp_q;
    p2_cand_q <= p1_cand_q;
    prod_q    <= hng_pkg::PROD_W'(osq_q) * hng_pkg::PROD_W'(s_q);
    if (p2_valid_q && trial_ok) begin
      q_q[p2_comp_q] <= p2_cand_q;
    end

    if (out_load) begin
      nx_q   <= hng_pkg::to_q15(q_q[hng_pkg::COMP_X], neg_x_q);
      ny_q   <= hng_pkg::to_q15(q_q[hng_pkg::COMP_Y], 1'b0);
      nz_q   <= hng_pkg::to_q15(q_q[hng_pkg::COMP_Z], neg_z_q);
      ocol_q <= vcol_q;
      orow_q <= vrow_q;
    end
  end

  // border vertices skip SQR/SUM; their neg flags are still loaded in DIFF and may be set,
  // but their x and z magnitudes are zero, so to_q15 yields zero whatever the sign

  assign out_valid_o     = out_valid_q;
  assign normal_x_o      = nx_q;
  assign normal_y_o      = ny_q;
  assign normal_z_o      = nz_q;
  assign vertex_column_o = ocol_q;
  assign vertex_row_o    = orow_q;

  // ---------------------------------------------------------------- assertions
  `HNG_ASSERT_NOW(a_trial_only_in_root, p2_valid_q, (state_q == ST_ITER) || (state_q == ST_DRAIN), "trial result outside root search")
  `HNG_ASSERT_NOW(a_slots_interleaved, p1_valid_q && p2_valid_q, p1_comp_q != p2_comp_q, "two trials of one component in flight")
  `HNG_ASSERT_NOW(a_idle_pipe_empty, in_ready_o, !p1_valid_q && !p2_valid_q, "sample taken with trials in flight")
  `HNG_ASSERT_NOW(a_column_in_grid, state_q == ST_DIFF, {1'b0, c_q} < side_eff, "column outside the grid")
  `HNG_ASSERT_NEXT(a_result_loaded, out_load, out_valid_q, "result not presented after load")

endmodule

`default_nettype wire

@@ tb/heightmap_normal_generator_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the heightmap normal generator: directed grids, random grids, predicted normals.
module heightmap_normal_generator_top_tb;
  import hng_pkg::*;

  typedef struct packed {
    logic [Q_W-1:0]    nx;
    logic [Q_W-1:0]    ny;
    logic [Q_W-1:0]    nz;
    logic [ADDR_W-1:0] col;
    logic [ADDR_W-1:0] row;
  } normal_t;

  // how a directed row gets its expectation
  typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_FIXED} exp_kind_e;

  typedef struct {
    logic [H_W-1:0] h;
    logic           fs;
    exp_kind_e      kind;
    normal_t        n;
  } dir_row_t;

  typedef enum int {IDLE_SEND_LIGHT, IDLE_SEND_HEAVY, IDLE_NONE} idle_mode_e;
  typedef enum int {TERRAIN_NOISE, TERRAIN_SLOPE, TERRAIN_SPIKE} terrain_e;

  localparam int      LONG_STALL   = 300;
  localparam int      DRAIN_CYCLES = 80;
  localparam int      MAX_REPORTS  = 40;
  localparam int      RANDOM_ITEMS = 150;  // per idling mode
  localparam normal_t NO_NORMAL    = '0;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_we_i      = 1'b0;
  logic [SIDE_W-1:0]        cfg_wdata_i   = '0;
  logic                     in_valid_i    = 1'b0;
  logic [H_W-1:0]           height_i      = '0;
  logic                     frame_start_i = 1'b0;
  logic                     out_ready_i   = 1'b0;
  logic                     in_ready_o;
  logic                     out_valid_o;
  logic signed [Q_W-1:0]    normal_x_o;
  logic signed [Q_W-1:0]    normal_y_o;
  logic signed [Q_W-1:0]    normal_z_o;
  logic [ADDR_W-1:0]        vertex_column_o;
  logic [ADDR_W-1:0]        vertex_row_o;

  // predictor state
  logic [SIDE_W-1:0] side_reg;
  logic [H_W-1:0]    line_above     [LINE_DEPTH];
  logic [H_W-1:0]    line_two_above [LINE_DEPTH];
  logic [H_W-1:0]    left_hold_q;
  int unsigned       col_q;
  int unsigned       row_q;

  normal_t  pending_normals[$];
  dir_row_t dir_tab[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_token   = 0;
  int stall_seen    = 0;
  int stall_left    = 0;
  int fail_count    = 0;
  int samples_sent  = 0;
  int normals_seen  = 0;
  int sides_written = 0;

  heightmap_normal_generator_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .height_i        (height_i),
    .frame_start_i   (frame_start_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .normal_x_o      (normal_x_o),
    .normal_y_o      (normal_y_o),
    .normal_z_o      (normal_z_o),
    .vertex_column_o (vertex_column_o),
    .vertex_row_o    (vertex_row_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Signed, rounded Q1.15 by bitwise root search: keep a bit while (2q-1)^2 * s <= 4 v^2 2^30.
  function automatic logic [Q_W-1:0] unit_component(input int v, input longint unsigned s);
    longint unsigned a, rhs, q, cand, odd;
    logic [Q_W:0]    wrapped;
    a   = (v < 0) ? longint'(-v) : longint'(v);
    rhs = (a * a) << 32;
    q   = 0;
    for (int b = Q_W - 1; b >= 0; b--) begin
      cand = q | (64'd1 << b);
      odd  = 2 * cand - 1;
      if (odd * odd * s <= rhs) q = cand;
    end
    if (q > longint'(Q_ONE)) q = longint'(Q_ONE);
    wrapped = 17'h10000 - 17'(q);
    return (v < 0) ? wrapped[Q_W-1:0] : q[Q_W-1:0];
  endfunction

  function automatic normal_t flat_normal(input int c, input int r);
    normal_t n;
    n = '{nx: '0, ny: Q_ONE, nz: '0, col: ADDR_W'(c), row: ADDR_W'(r)};
    return n;
  endfunction

  // Advances the grid position for one sample; returns 1 when a normal is due.
  function automatic bit predict_normal(input logic [H_W-1:0] h, input logic fs,
                                        output normal_t n);
    int unsigned     side, c, r, vr;
    logic [H_W-1:0]  mid, down, right, left;
    int              dl, du;
    longint unsigned s;
    bit              emits;
    side = side_reg;
    if (side < SIDE_MIN) side = SIDE_MIN;
    if (side > SIDE_MAX) side = SIDE_MAX;
    if (fs) begin
      col_q = 0;
      row_q = 0;
    end
    if (col_q >= side) begin
      col_q = 0;
      row_q++;
    end
    if (row_q >= side) row_q = 0;
    c = col_q;
    r = row_q;
    if (c == 0) left_hold_q = '0;
    mid   = line_above[c];
    down  = line_two_above[c];
    right = (c + 1 < LINE_DEPTH) ? line_above[c+1] : '0;
    left  = left_hold_q;
    emits = 1'b0;
    n     = NO_NORMAL;
    if (r >= 1) begin
      vr = r - 1;
      if (c >= 1 && c + 2 <= side && vr >= 1) begin
        dl   = int'(right) - int'(left);
        du   = int'(h) - int'(down);
        s    = longint'(dl * dl + du * du + 100);
        n.nx = unit_component(-dl, s);
        n.ny = unit_component(10, s);
        n.nz = unit_component(-du, s);
      end else begin
        n.ny = Q_ONE;
      end
      n.col = ADDR_W'(c);
      n.row = ADDR_W'(vr);
      emits = 1'b1;
    end
    line_two_above[c] = mid;
    line_above[c]     = h;
    left_hold_q       = mid;
    col_q = c + 1;
    if (col_q >= side) begin
      col_q = 0;
      row_q = r + 1;
      if (row_q >= side) row_q = 0;
    end
    return emits;
  endfunction

  task automatic send_sample(input logic [H_W-1:0] h, input logic fs, input exp_kind_e kind,
                             input normal_t fixed);
    normal_t n;
    bit      emits;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    height_i      <= h;
    frame_start_i <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    samples_sent++;
    emits = predict_normal(h, fs, n);
    if (kind != EXP_PRED && emits != (kind == EXP_FIXED)) begin
      fail_count++;
      $display("%0t directed sample %0d: expected result %0d, predicted %0d",
               $time, samples_sent, kind == EXP_FIXED, emits);
    end
    if (emits) pending_normals.push_back(kind == EXP_FIXED ? fixed : n);
  endtask

  // Drain, let any result-free sample finish, then write the side register.
  task automatic write_side(input logic [SIDE_W-1:0] v);
    in_valid_i <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    side_reg = v;
    sides_written++;
  endtask

  task automatic run_grid(input int count, input bit fresh, input terrain_e style,
                          input int noise_pct);
    logic [H_W-1:0] h, level;
    logic           fs;
    level = H_W'($urandom);
    for (int i = 0; i < count; i++) begin
      case (style)
        TERRAIN_NOISE: h = H_W'($urandom);
        TERRAIN_SLOPE: begin
          level = level + H_W'($urandom_range(6)) - H_W'(3);
          h     = level;
        end
        default: begin
          if ($urandom_range(7) == 0) h = $urandom_range(1) ? '1 : '0;
          else                        h = level;
        end
      endcase
      fs = (i == 0) ? fresh : ($urandom_range(99) < noise_pct);
      send_sample(h, fs, EXP_PRED, NO_NORMAL);
    end
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_SEND_LIGHT: begin
        send_idle_pct = 36;
        recv_idle_pct = 72;
      end
      IDLE_SEND_HEAVY: begin
        send_idle_pct = 72;
        recv_idle_pct = 36;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Result side: checks each transfer and draws out_ready for the next cycle.
  always @(posedge clk_i) begin : rx_side
    normal_t want, got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {normal_x_o, normal_y_o, normal_z_o, vertex_column_o, vertex_row_o};
        normals_seen++;
        if (pending_normals.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t unexpected normal at column %0d row %0d, expected none",
                     $time, got.col, got.row);
        end else begin
          want = pending_normals.pop_front();
          check_field("normal_x", $signed(want.nx), $signed(got.nx));
          check_field("normal_y", $signed(want.ny), $signed(got.ny));
          check_field("normal_z", $signed(want.nz), $signed(got.nz));
          check_field("vertex_column", int'(want.col), int'(got.col));
          check_field("vertex_row", int'(want.row), int'(got.row));
        end
      end
      if (stall_token != stall_seen) begin
        stall_seen = stall_token;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : main_seq
    int          side, count;
    logic [SIDE_W-1:0] side_cfg;
    side_reg    = SIDE_RESET;
    left_hold_q = '0;
    col_q       = 0;
    row_q       = 0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      line_above[i]     = '0;
      line_two_above[i] = '0;
    end
    // 3x3 grids: row 0 gives nothing, borders give (0,1,0), one interior vertex per grid
    dir_tab = '{
      '{8'd255, 1'b1, EXP_NONE,  NO_NORMAL},
      '{8'd0,   1'b0, EXP_NONE,  NO_NORMAL},
      '{8'd255, 1'b0, EXP_NONE,  NO_NORMAL},
      '{8'd0,   1'b0, EXP_FIXED, flat_normal(0, 0)},
      '{8'd200, 1'b0, EXP_FIXED, flat_normal(1, 0)},
      '{8'd255, 1'b0, EXP_FIXED, flat_normal(2, 0)},
      '{8'd17,  1'b0, EXP_FIXED, flat_normal(0, 1)},
      '{8'd255, 1'b0, EXP_PRED,  NO_NORMAL},          // steepest rise both ways
      '{8'd3,   1'b0, EXP_FIXED, flat_normal(2, 1)},
      // no frame_start: position wraps to the origin by itself
      '{8'd0,   1'b0, EXP_NONE,  NO_NORMAL},
      '{8'd255, 1'b0, EXP_NONE,  NO_NORMAL},
      '{8'd0,   1'b0, EXP_NONE,  NO_NORMAL},
      '{8'd255, 1'b0, EXP_FIXED, flat_normal(0, 0)},
      '{8'd7,   1'b0, EXP_FIXED, flat_normal(1, 0)},
      '{8'd0,   1'b0, EXP_FIXED, flat_normal(2, 0)},
      '{8'd9,   1'b0, EXP_FIXED, flat_normal(0, 1)},
      '{8'd0,   1'b0, EXP_PRED,  NO_NORMAL},          // steepest fall both ways
      '{8'd9,   1'b0, EXP_FIXED, flat_normal(2, 1)},
      // restart mid-row, then flat ground saturates y
      '{8'd100, 1'b0, EXP_NONE,  NO_NORMAL},
      '{8'd100, 1'b1, EXP_NONE,  NO_NORMAL},
      '{8'd100, 1'b0, EXP_NONE,  NO_NORMAL},
      '{8'd100, 1'b0, EXP_NONE,  NO_NORMAL},
      '{8'd100, 1'b0, EXP_FIXED, flat_normal(0, 0)},
      '{8'd100, 1'b0, EXP_FIXED, flat_normal(1, 0)},
      '{8'd100, 1'b0, EXP_FIXED, flat_normal(2, 0)},
      '{8'd100, 1'b0, EXP_FIXED, flat_normal(0, 1)},
      '{8'd100, 1'b0, EXP_FIXED, flat_normal(1, 1)},
      '{8'd100, 1'b0, EXP_FIXED, flat_normal(2, 1)}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // side from reset, up to the first interior vertices
    set_idling(IDLE_NONE);
    run_grid(2 * 257 + 3, 1'b1, TERRAIN_NOISE, 0);

    write_side(SIDE_MIN);
    set_idling(IDLE_SEND_LIGHT);
    foreach (dir_tab[i])
      send_sample(dir_tab[i].h, dir_tab[i].fs, dir_tab[i].kind, dir_tab[i].n);

    // side clamps and the largest grid, kept to a few rows
    set_idling(IDLE_NONE);
    write_side('0);
    run_grid(12, 1'b1, TERRAIN_NOISE, 0);
    write_side('1);
    run_grid(2 * 1024 + 40, 1'b1, TERRAIN_SLOPE, 0);
    write_side(SIDE_MAX);
    run_grid(1024 + 3, 1'b1, TERRAIN_NOISE, 0);

    // shrink mid-grid: column past the new side, then row past the new side
    write_side(11'd8);
    run_grid(8 * 3 + 5, 1'b1, TERRAIN_SLOPE, 0);
    write_side(11'd5);
    run_grid(12, 1'b0, TERRAIN_SLOPE, 0);
    write_side(11'd8);
    run_grid(8 * 6 + 2, 1'b1, TERRAIN_NOISE, 0);
    write_side(11'd5);
    run_grid(10, 1'b0, TERRAIN_NOISE, 0);

    for (int m = IDLE_SEND_LIGHT; m <= IDLE_NONE; m++) begin
      set_idling(idle_mode_e'(m));
      count = 0;
      while (count < RANDOM_ITEMS) begin
        side     = ($urandom_range(4) == 0) ? $urandom_range(11, 40) : $urandom_range(3, 10);
        side_cfg = SIDE_W'(side);
        if ($urandom_range(9) == 0) begin
          side     = 3;
          side_cfg = SIDE_W'($urandom_range(0, 2));
        end
        write_side(side_cfg);
        // block fills up behind a long output stall
        if (m == IDLE_NONE && count == 0) stall_token++;
        side = $urandom_range(2 * side + 1, side * side + side);
        if (side > 160) side = 160;
        run_grid(side, 1'b1, terrain_e'($urandom_range(2)), 2);
        count += side;
      end
    end

    in_valid_i <= 1'b0;
    for (int i = 0; i < 200000 && pending_normals.size() != 0; i++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_normals.size() != 0) begin
      fail_count += pending_normals.size();
      $display("%0t %0d normals never arrived", $time, pending_normals.size());
    end
    $display("Sent %0d height samples and checked %0d normals over %0d side settings,",
             samples_sent, normals_seen, sides_written);
    $display("covering borders, interior slopes, side clamps, restarts and mid-grid shrinks.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/hng_pkg.sv
src/heightmap_normal_generator_top.sv
tb/heightmap_normal_generator_top_tb.sv
